@@ rtl/core/wsa_pkg.sv @@
// ============================================================================
// wsa_pkg
// shared widths, constants and the divider request and response structs for the step test
// ============================================================================
`default_nettype none
package wsa_pkg;
    localparam int unsigned QW = 48;
    localparam int unsigned NW = 53;      // width of reductions and sums
    localparam int unsigned LW = 5;       // width of the window length field in the config data
    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] QONE = 48'sd65536;
    localparam logic [0:0] CFG_WINDOW = 1'b0;
    localparam logic [0:0] CFG_THRESH = 1'b1;

    typedef struct packed {
        logic            start;
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic signed [QW-1:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ rtl/core/wsa_div.sv @@
// ============================================================================
// wsa_div
// serial signed q16 divider, one quotient bit per cycle, saturating
// ============================================================================
`default_nettype none
module wsa_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wsa_pkg::t_div_req     i_req,
    output wsa_pkg::t_div_rsp     o_rsp
);
    import wsa_pkg::*;
    localparam int unsigned AW = NW + 16;   // magnitude of n shifted by 16
    localparam int unsigned CW = 7;

    logic [AW-1:0]   r_a;      // remaining dividend bits (shift out msb first)
    logic [NW:0]     r_rem;
    logic [NW-1:0]   r_b;
    logic [AW-1:0]   r_q;
    logic            r_neg;
    logic            r_zero;
    logic            r_nsgn;
    logic            r_nzero;
    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;

    logic [NW-1:0]   mag_n, mag_d;
    logic [NW:0]     rem_sh;
    logic            fits;
    logic [QW-1:0]   qres;

    always_comb begin
        mag_n = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
        mag_d = i_req.den[NW-1] ? NW'(-i_req.den) : NW'(i_req.den);
        rem_sh = {r_rem[NW-1:0], r_a[AW-1]};
        fits = rem_sh >= {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_a     <= {mag_n, 16'd0};
            r_rem   <= '0;
            r_b     <= mag_d;
            r_q     <= '0;
            r_neg   <= i_req.num[NW-1] ^ i_req.den[NW-1];
            r_zero  <= (i_req.den == '0);
            r_nsgn  <= i_req.num[NW-1];
            r_nzero <= (i_req.num == '0);
        end else if (r_busy) begin
            r_a   <= {r_a[AW-2:0], 1'b0};
            r_rem <= fits ? rem_sh - {1'b0, r_b} : rem_sh;
            r_q   <= {r_q[AW-2:0], fits};
        end
    end

    // a quotient of 2^31 or more saturates; a zero divisor gives QMIN, 0 or QMAX
    always_comb begin
        if (r_zero) begin
            qres = r_nsgn ? QMIN : (r_nzero ? '0 : QMAX);
        end else if (r_q[AW-1:QW-1] != '0) begin
            if (r_neg) qres = (r_q == {{(AW-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}})
                               ? QMIN : QMIN;
            else qres = QMAX;
        end else begin
            qres = r_neg ? QW'(-r_q[QW-1:0]) : r_q[QW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = qres;
endmodule
`default_nettype wire

@@ rtl/core/windowed_step_acceptance.sv @@
// ============================================================================
// windowed_step_acceptance
// nonmonotone trust-region ratio test over a ring of accepted steps
// ============================================================================
// channels: s_axis takes one step (tdata = current_merit, trial_merit,
// model_merit, 48 bits each from bit 0). m_axis returns one result per step
// (tdata = larger of ratio and history ratio, 48 bits; tuser = accepted).
// configuration: i_cfg_we/i_cfg_idx/i_cfg_data; index 0 is the window length
// (writing it empties the history), index 1 the acceptance threshold.
// flow: a step is walked through the merit memory once to find the oldest
// highest merit; unless that merit is below the trial merit, a second walk
// sums the stored model reductions from it on. the serial divider then runs
// its 69 quotient bits for the history quotient after a second walk and
// again for the current quotient; with an empty history the walks are
// skipped.
// one step is in flight at a time; s_axis_tready is low while busy.
// the result waits in an output register while the receiver stalls; a step
// that finishes while that register is still full holds until it drains.
// reset empties the history and clears the control registers; memory
// contents are never read before written, so they get no clearing pass.
// ============================================================================
`default_nettype none
module windowed_step_acceptance #(
    parameter int unsigned WINDOW_MAX = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [143:0]            s_axis_tdata,  // current, trial, model
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [47:0]                  m_axis_tdata,  // larger of ratio and history ratio
    output logic                         m_axis_tuser,  // accepted
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [47:0]             i_cfg_data
);
    import wsa_pkg::*;
    localparam int unsigned SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned CW = $clog2(WINDOW_MAX + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_SCANW = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_SUMW  = 4'd4;
    localparam logic [3:0] ST_DIVH  = 4'd5;
    localparam logic [3:0] ST_WAITH = 4'd6;
    localparam logic [3:0] ST_DIVC  = 4'd7;
    localparam logic [3:0] ST_WAITC = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // history memories, one synchronous read port each
    logic signed [QW-1:0] merit_mem [WINDOW_MAX];
    logic signed [QW-1:0] red_mem   [WINDOW_MAX];
    logic signed [QW-1:0] r_mrd, r_rrd;
    logic [SW-1:0]        rd_addr;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;

    logic [3:0]           r_state;
    logic [CW-1:0]        r_num;       // effective window
    logic signed [QW-1:0] r_thr;
    logic [SW-1:0]        r_newest;
    logic [CW-1:0]        r_fill;
    logic signed [QW-1:0] r_cur, r_trial;
    logic signed [NW-1:0] r_exact, r_model;
    logic [CW-1:0]        r_len;
    logic [SW-1:0]        r_oldest;
    logic [CW-1:0]        r_k;         // issued index
    logic [CW-1:0]        r_kr;        // index of data returning
    logic signed [QW-1:0] r_ref;
    logic [CW-1:0]        r_refpos;
    logic signed [NW-1:0] r_sum;
    logic signed [QW-1:0] r_hist;
    logic signed [QW-1:0] r_ratio;
    logic                 r_ovalid;
    logic signed [QW-1:0] r_odata;
    logic                 r_oacc;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic [SW:0]          slot_sum;
    logic [SW-1:0]        rd_slot;
    logic signed [QW-1:0] best;
    logic                 acc;
    logic [SW-1:0]        push_slot;
    logic                 done_go;     // result moves into the output register

    // ring slot for walk index k: (oldest + k) mod num
    always_comb begin
        slot_sum = {1'b0, r_oldest} + (SW+1)'(r_k);
        rd_slot  = (slot_sum >= (SW+1)'(r_num)) ? SW'(slot_sum - (SW+1)'(r_num))
                                                : SW'(slot_sum);
        rd_addr  = rd_slot;
        best     = (r_ratio > r_hist) ? r_ratio : r_hist;
        acc      = best >= r_thr;
        push_slot = (r_fill == '0) ? '0 :
                    ((CW'(r_newest) + 1'b1 >= r_num) ? '0 : SW'(r_newest + 1'b1));
        done_go  = (r_state == ST_DONE) && (!r_ovalid || m_axis_tready);
        wr_en    = done_go && acc && (r_num != '0);
        wr_addr  = push_slot;
    end

    always_ff @(posedge i_clk) begin
        r_mrd <= merit_mem[rd_addr];
        r_rrd <= red_mem[rd_addr];
        if (wr_en) begin
            merit_mem[wr_addr] <= r_cur;
            red_mem[wr_addr]   <= (r_model > NW'(QMAX)) ? QMAX :
                                  (r_model < NW'(QMIN)) ? QMIN : QW'(r_model);
        end
    end

    wsa_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        div_req.start = (r_state == ST_DIVH) || (r_state == ST_DIVC);
        div_req.num   = (r_state == ST_DIVH) ? NW'(r_ref) - NW'(r_trial) : r_exact;
        div_req.den   = (r_state == ST_DIVH) ? r_sum + r_model : r_model;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oacc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_num    <= '0;
            r_thr    <= '0;
            r_newest <= SW'(WINDOW_MAX - 1);
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (done_go) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW) begin
                    r_num    <= (32'(i_cfg_data[LW-1:0]) > WINDOW_MAX)
                                ? CW'(WINDOW_MAX) : CW'(i_cfg_data[LW-1:0]);
                    r_newest <= SW'(WINDOW_MAX - 1);
                    r_fill   <= '0;
                end else begin
                    r_thr <= i_cfg_data;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cur   <= s_axis_tdata[47:0];
                        r_trial <= s_axis_tdata[95:48];
                        r_exact <= NW'($signed(s_axis_tdata[47:0]))
                                 - NW'($signed(s_axis_tdata[95:48]));
                        r_model <= NW'($signed(s_axis_tdata[47:0]))
                                 - NW'($signed(s_axis_tdata[143:96]));
                        r_len   <= (r_fill > r_num) ? r_num : r_fill;
                        // oldest = newest + 1 - len (mod num) follows in ST_SCAN; newest < num when len > 0
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= ST_SCAN;
                        begin
                            r_oldest <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    // compute oldest from newest and len
                    if (r_len == '0 || r_num == '0) begin
                        r_state <= ST_DIVC;
                        r_hist  <= QMIN;
                        r_refpos <= '0;
                    end else begin
                        r_oldest <= (CW'(r_newest) + 1'b1 >= r_len)
                                    ? SW'(CW'(r_newest) + 1'b1 - r_len)
                                    : SW'(CW'(r_newest) + 1'b1 + r_num - r_len);
                        r_k   <= '0;
                        r_kr  <= '0;
                        r_state <= ST_SCANW;
                        r_refpos <= '1;
                    end
                end
                ST_SCANW: begin
                    // issue address r_k, data for r_kr arrives next cycle
                    if (r_refpos != '1 || r_kr != '0) begin
                        if (r_kr == CW'(1) || r_mrd > r_ref) begin
                            r_ref    <= r_mrd;
                            r_refpos <= r_kr - 1'b1;
                        end
                    end
                    if (r_refpos == '1 && r_kr == '0) r_refpos <= '0;
                    if (r_kr == r_len) begin
                        r_k     <= '0;
                        r_kr    <= '0;
                        r_state <= ST_SUM;
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_kr <= r_kr + 1'b1;
                    end
                end
                ST_SUM: begin
                    if (r_ref < r_trial) begin
                        r_state <= ST_DIVC;
                        r_hist  <= QMIN;
                    end else begin
                        r_k     <= r_refpos;
                        r_kr    <= r_refpos;
                        r_state <= ST_SUMW;
                    end
                end
                ST_SUMW: begin
                    if (r_kr != r_refpos) r_sum <= r_sum + NW'(r_rrd);
                    if (r_kr == r_len) r_state <= ST_DIVH;
                    else begin
                        r_k  <= r_k + 1'b1;
                        r_kr <= r_kr + 1'b1;
                    end
                end
                ST_DIVH:  r_state <= ST_WAITH;
                ST_WAITH: if (div_rsp.done) begin
                    r_hist  <= div_rsp.quo;
                    r_state <= ST_DIVC;
                end
                ST_DIVC:  r_state <= ST_WAITC;
                ST_WAITC: if (div_rsp.done) begin
                    r_ratio <= (r_exact == r_model) ? QONE : div_rsp.quo;
                    if (r_hist == QMIN && !(r_len != '0 && r_num != '0
                                            && r_ref >= r_trial))
                        r_hist <= div_rsp.quo;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (done_go) begin
                        r_odata  <= best;
                        r_oacc   <= acc;
                        if (acc && r_num != '0) begin
                            r_newest <= push_slot;
                            if (r_fill < r_num) r_fill <= r_fill + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // the fill count never passes WINDOW_MAX
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_MAX))
        else $error("fill count above window");
    // a result only leaves the done state once the output register is free
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ovalid && !m_axis_tready) |=> r_state == ST_DONE)
        else $error("result overwritten");
    // no step is taken while one is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
endmodule
`default_nettype wire
